@@ src/multichannel_ema_adc_filter_defines.svh @@
// ----------------------------------------------------------------------------
// multichannel_ema_adc_filter_defines
// assertion macros used by the filter's back rtl file
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_EMA_ADC_FILTER_DEFINES_SVH
`define MULTICHANNEL_EMA_ADC_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MCEMA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mcema assertion failed");
// next-cycle implication
`define MCEMA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mcema assertion failed");
`else
`define MCEMA_ASSERT_NOW(label, clk, rstn, ante, cons)
`define MCEMA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ src/mcema_pkg.sv @@
// ----------------------------------------------------------------------------
// mcema_pkg
// shared widths, codes and types of the multichannel ema adc filter
// ----------------------------------------------------------------------------
package mcema_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int CHAN_W        = 5;
    localparam int NUM_SLOTS     = 3;
    localparam int AVG_SHIFT     = 3;
    localparam int ACC_W         = SAMPLE_W + AVG_SHIFT;
    localparam int SLOT_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NUM_CFG_REGS  = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int ACC_HALF      = 1 << (AVG_SHIFT - 1);

    localparam int MV_FULL_SCALE  = 3300;
    localparam int ADC_FULL_SCALE = 4095;
    localparam int SAMPLE_MAX     = 4095;
    localparam int MV_W           = 12;
    // value * 3300 fits in sample width plus 12 bits
    localparam int PROD_W         = SAMPLE_W + 12;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_C = 2'd2;

    // classified word passed from front to back
    typedef struct packed {
        logic                clear;
        logic                matched;
        logic [SLOT_W-1:0]   slot;
        logic [SAMPLE_W-1:0] raw;
    } item_t;

    function automatic logic [CHAN_W-1:0] slot_reset_id(input int unsigned slot);
        logic [CHAN_W-1:0] id;
        unique case (slot)
            0:       id = CHAN_W'(0);
            1:       id = CHAN_W'(2);
            2:       id = CHAN_W'(6);
            default: id = '0;
        endcase
        return id;
    endfunction

endpackage

@@ src/mcema_front.sv @@
// ----------------------------------------------------------------------------
// mcema_front
// takes input words, holds the channel table and classifies each word
// ----------------------------------------------------------------------------
module mcema_front
    import mcema_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CHAN_W-1:0]     cfg_data,
    output logic                  push_valid,
    input  logic                  push_ready,
    output item_t                 push_item
);

    logic [CHAN_W-1:0] slot_channel_reg [NUM_SLOTS];
    logic              front_valid_reg, front_valid_next;
    item_t             front_item_reg, front_item_next;
    logic [CHAN_W-1:0] in_chan;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;

    assign cfg_ready = 1'b1;
    assign in_chan   = s_tdata[CHAN_W-1:0];

    // channel table, slots without a register keep their reset id
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!aresetn) begin
                slot_channel_reg[i] <= slot_reset_id(i);
            end else if (cfg_valid && i < NUM_CFG_REGS && cfg_index == CFG_IDX_W'(i)) begin
                slot_channel_reg[i] <= cfg_data;
            end
        end
    end

    // lowest matching slot wins
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_channel_reg[i] == in_chan) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    assign s_tready   = !front_valid_reg || push_ready;
    assign push_valid = front_valid_reg;
    assign push_item  = front_item_reg;

    always_comb begin
        front_valid_next = front_valid_reg;
        front_item_next  = front_item_reg;
        if (s_tready) begin
            front_valid_next = s_tvalid;
            if (s_tvalid) begin
                front_item_next.clear   = (s_tuser == REQ_CLEAR);
                front_item_next.matched = hit && (s_tuser == REQ_SAMPLE);
                front_item_next.slot    = hit_slot;
                front_item_next.raw     = s_tdata[CHAN_W +: SAMPLE_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
        front_item_reg <= front_item_next;
    end

endmodule

@@ src/mcema_queue.sv @@
// ----------------------------------------------------------------------------
// mcema_queue
// two-entry queue between the classifying front and the filter back
// ----------------------------------------------------------------------------
module mcema_queue
    import mcema_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ src/mcema_back.sv @@
// ----------------------------------------------------------------------------
// mcema_back
// slot accumulators, average update and millivolt conversion pipeline
// ----------------------------------------------------------------------------
`include "multichannel_ema_adc_filter_defines.svh"

module mcema_back
    import mcema_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  item_t                  q_item,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser
);

    // value*3300 split as q0*4096 + lo = q0*4095 + (q0 + lo), one correction
    function automatic logic [MV_W-1:0] mv_from_product(input logic [PROD_W-1:0] prod);
        logic [MV_W-1:0]   q0;
        logic [SAMPLE_W:0] rem;
        q0  = prod[PROD_W-1:SAMPLE_W];
        rem = {1'b0, prod[SAMPLE_W-1:0]} + (SAMPLE_W + 1)'(q0);
        return (rem >= (SAMPLE_W + 1)'(ADC_FULL_SCALE)) ? q0 + MV_W'(1) : q0;
    endfunction

    logic [ACC_W-1:0]    acc_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] seeded_reg;

    logic                s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [SAMPLE_W-1:0] s1_raw_reg, s1_filt_reg, s1_filt_next;
    logic                s1_matched_reg;
    logic [SAMPLE_W-1:0] s2_raw_reg, s2_filt_reg;
    logic                s2_matched_reg;
    logic [PROD_W-1:0]   s2_raw_prod_reg, s2_filt_prod_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                out_matched_reg;

    logic                adv, pop;
    logic [ACC_W-1:0]    acc_cur, acc_upd;
    logic [ACC_W:0]      cur_rnd, upd_rnd;
    logic [SAMPLE_W:0]   cur_avg, upd_avg;
    logic [SAMPLE_W-1:0] upd_sat;

    assign adv     = !out_valid_reg || m_tready;
    assign pop     = q_valid && adv;
    assign q_ready = adv;

    // average update
    always_comb begin
        acc_cur = acc_reg[q_item.slot];
        cur_rnd = {1'b0, acc_cur} + (ACC_W + 1)'(ACC_HALF);
        cur_avg = cur_rnd[ACC_W:AVG_SHIFT];
        acc_upd = acc_cur + ACC_W'(q_item.raw) - ACC_W'(cur_avg);
        upd_rnd = {1'b0, acc_upd} + (ACC_W + 1)'(ACC_HALF);
        upd_avg = upd_rnd[ACC_W:AVG_SHIFT];
        upd_sat = (upd_avg > (SAMPLE_W + 1)'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX)
                                                          : upd_avg[SAMPLE_W-1:0];
        if (q_item.clear) begin
            s1_filt_next = '0;
        end else if (q_item.matched && seeded_reg[q_item.slot]) begin
            s1_filt_next = upd_sat;
        end else begin
            s1_filt_next = q_item.raw;
        end
    end

    // slot state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (pop) begin
            if (q_item.clear) begin
                seeded_reg <= '0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    acc_reg[i] <= '0;
                end
            end else if (q_item.matched) begin
                seeded_reg[q_item.slot] <= 1'b1;
                if (seeded_reg[q_item.slot]) begin
                    acc_reg[q_item.slot] <= acc_upd;
                end else begin
                    acc_reg[q_item.slot] <= {q_item.raw, AVG_SHIFT'(0)};
                end
            end
        end
    end

    // result pipeline, all stages move together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
        if (adv) begin
            s1_raw_reg       <= q_item.clear ? '0 : q_item.raw;
            s1_filt_reg      <= s1_filt_next;
            s1_matched_reg   <= q_item.matched && !q_item.clear;
            s2_raw_reg       <= s1_raw_reg;
            s2_filt_reg      <= s1_filt_reg;
            s2_matched_reg   <= s1_matched_reg;
            s2_raw_prod_reg  <= PROD_W'(s1_raw_reg) * PROD_W'(MV_FULL_SCALE);
            s2_filt_prod_reg <= PROD_W'(s1_filt_reg) * PROD_W'(MV_FULL_SCALE);
            out_data_reg     <= {mv_from_product(s2_filt_prod_reg),
                                 mv_from_product(s2_raw_prod_reg),
                                 s2_filt_reg, s2_raw_reg};
            out_matched_reg  <= s2_matched_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_matched_reg;

    `MCEMA_ASSERT_NEXT(a_clear_empties_slots, aclk, aresetn, pop && q_item.clear, seeded_reg == '0)
    `MCEMA_ASSERT_NEXT(a_match_seeds_slot, aclk, aresetn, pop && q_item.matched && !q_item.clear, seeded_reg[$past(q_item.slot)])
    `MCEMA_ASSERT_NOW(a_unmatched_passes_raw, aclk, aresetn, s1_valid_reg && !s1_matched_reg, s1_filt_reg == s1_raw_reg)
    `MCEMA_ASSERT_NOW(a_mv_in_range, aclk, aresetn, out_valid_reg, out_data_reg[2*SAMPLE_W +: MV_W] <= MV_W'(MV_FULL_SCALE) && out_data_reg[2*SAMPLE_W+MV_W +: MV_W] <= MV_W'(MV_FULL_SCALE))

endmodule

@@ src/multichannel_ema_adc_filter.sv @@
// ----------------------------------------------------------------------------
// multichannel_ema_adc_filter
// three-slot exponential moving average filter for tagged 12-bit adc samples
// ----------------------------------------------------------------------------
// Each input word is a 12-bit sample tagged with a 5-bit channel id, or a clear
// request (tuser high) that zeroes every slot and returns an all-zero result.
// A sample whose channel matches a tracked slot (lowest slot wins on duplicate
// ids) updates that slot's Q3 average: the first sample seeds it, later ones
// move it by raw minus the rounded average; the rounded average is returned.
// Unmatched samples come back unfiltered with tuser low. Both values are also
// returned in millivolts, value*3300/4095 truncated. Exactly one result word
// per input word, in order. The block takes one word per cycle while the
// output is not stalled. An accepted word passes through the input register,
// the two-entry queue, the average update stage, the millivolt multiply stage
// and the correction into the output register.
// The user must write slot channel ids through the cfg port only while idle;
// the block does not enforce this, and an index of three is ignored.
// ----------------------------------------------------------------------------
module multichannel_ema_adc_filter
    import mcema_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // sample input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // channel_id[4:0], raw_sample[16:5], zero pad
    input  logic                   s_tuser,   // req_type
    // channel table writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CHAN_W-1:0]      cfg_data,
    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // raw_value[11:0], filtered_value[23:12],
                                              // raw_millivolts[35:24],
                                              // filtered_millivolts[47:36]
    output logic                   m_tuser    // slot_matched
);

    // classified word from the front into the queue
    logic  push_valid, push_ready;
    item_t push_item;
    // queue head into the filter back
    logic  q_valid, q_ready;
    item_t q_item;

    // front: input register, channel table and slot lookup
    mcema_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // short queue so front and back stall independently
    mcema_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // back: slot state update and millivolt pipeline with output register
    mcema_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stream test of the three-slot ema adc filter
// ----------------------------------------------------------------------------
// A queue of adc words is filled by the stimulus process and drained by a
// clocked driver. Every accepted word runs through a local filter predictor
// that keeps its own accumulators, seeded flags and channel table. Each
// result word is checked field by field against the oldest prediction. The
// run goes through four phases with different channel tables and different
// idle and stall rates on both sides. One long output hold-off fills the
// pipe and pushes back on the input.
// ----------------------------------------------------------------------------
module tb;
    import mcema_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SPARE = 2'd3;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_WORDS  = 470;

    typedef struct packed {
        logic                req;
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] raw;
    } adc_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw;
        logic [SAMPLE_W-1:0] filt;
        logic [MV_W-1:0]     raw_mv;
        logic [MV_W-1:0]     filt_mv;
        logic                matched;
    } adc_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CHAN_W-1:0]      cfg_data  = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    // predictor state
    logic [CHAN_W-1:0] slot_chan [NUM_SLOTS];
    logic [ACC_W-1:0]  avg_acc   [NUM_SLOTS];
    logic              seeded    [NUM_SLOTS];

    adc_word_t   adc_words[$];
    adc_result_t pending_results[$];

    int unsigned offered_count  = 0;
    int unsigned accepted_count = 0;
    int unsigned error_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holds_asked    = 0;
    int unsigned holds_served   = 0;
    int unsigned stall_left     = 0;

    multichannel_ema_adc_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [MV_W-1:0] to_mv(input logic [SAMPLE_W-1:0] v);
        int unsigned prod;
        prod = 32'(v) * 32'(MV_FULL_SCALE);
        return MV_W'(prod / 32'(ADC_FULL_SCALE));
    endfunction

    // one word through the filter, updating the local slot state
    function automatic adc_result_t filter_sample(input adc_word_t w);
        adc_result_t         r;
        int unsigned         acc_now;
        int unsigned         cur;
        logic [SAMPLE_W-1:0] filt;
        logic                hit;
        r = '0;
        if (w.req == REQ_CLEAR) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                avg_acc[s] = '0;
                seeded[s]  = 1'b0;
            end
            return r;
        end
        filt = w.raw;
        hit  = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            // lowest slot wins on duplicate ids
            if (!hit && slot_chan[s] == w.chan) begin
                hit = 1'b1;
                if (!seeded[s]) begin
                    avg_acc[s] = ACC_W'(w.raw) << AVG_SHIFT;
                    seeded[s]  = 1'b1;
                end else begin
                    acc_now    = 32'(avg_acc[s]);
                    cur        = (acc_now + 32'(ACC_HALF)) >> AVG_SHIFT;
                    acc_now    = acc_now + 32'(w.raw) - cur;
                    avg_acc[s] = acc_now[ACC_W-1:0];
                    cur        = (32'(avg_acc[s]) + 32'(ACC_HALF)) >> AVG_SHIFT;
                    filt       = (cur > 32'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX)
                                                         : SAMPLE_W'(cur);
                end
            end
        end
        r.raw     = w.raw;
        r.filt    = filt;
        r.raw_mv  = to_mv(w.raw);
        r.filt_mv = to_mv(filt);
        r.matched = hit;
        return r;
    endfunction

    // input handshake capture, prediction and result check
    always @(posedge aclk) begin
        adc_word_t   w;
        adc_result_t got;
        adc_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                w.req  = s_tuser;
                w.chan = s_tdata[4:0];
                w.raw  = s_tdata[16:5];
                pending_results.push_back(filter_sample(w));
                accepted_count++;
            end
            if (m_tvalid && m_tready) begin
                got.raw     = m_tdata[11:0];
                got.filt    = m_tdata[23:12];
                got.raw_mv  = m_tdata[35:24];
                got.filt_mv = m_tdata[47:36];
                got.matched = m_tuser;
                if (pending_results.size() == 0) begin
                    if (error_count < 10)
                        $display("unexpected result word raw=%0d filt=%0d rmv=%0d fmv=%0d m=%0b",
                                 got.raw, got.filt, got.raw_mv, got.filt_mv, got.matched);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        if (error_count < 10) begin
                            $write("mismatch: raw %0d/%0d filt %0d/%0d ",
                                   want.raw, got.raw, want.filt, got.filt);
                            $display("rmv %0d/%0d fmv %0d/%0d matched %0b/%0b %s",
                                     want.raw_mv, got.raw_mv, want.filt_mv, got.filt_mv,
                                     want.matched, got.matched, "(expected/actual)");
                        end
                        error_count++;
                    end
                end
            end
        end
    end

    // sample driver: holds the word until taken, then offers the next one
    always @(negedge aclk) begin
        adc_word_t w;
        if (!s_tvalid || accepted_count == offered_count) begin
            if (adc_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = adc_words.pop_front();
                s_tdata  <= {7'd0, w.raw, w.chan};
                s_tuser  <= w.req;
                s_tvalid <= 1'b1;
                offered_count++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready, with an occasional long hold-off
    always @(negedge aclk) begin
        if (holds_served != holds_asked) begin
            holds_served++;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_word(input logic req, input logic [CHAN_W-1:0] chan,
                             input logic [SAMPLE_W-1:0] raw);
        adc_word_t w;
        w.req  = req;
        w.chan = chan;
        w.raw  = raw;
        adc_words.push_back(w);
    endtask

    // mostly tracked channels so the averages run long between clears
    task automatic push_random(input int count);
        int unsigned      pick;
        logic [SAMPLE_W-1:0] raw;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            raw  = SAMPLE_W'($urandom);
            if ($urandom_range(9) == 0)
                raw = $urandom_range(1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
            if (pick < 2)
                push_word(REQ_CLEAR, CHAN_W'($urandom), SAMPLE_W'($urandom));
            else if (pick < 80)
                push_word(REQ_SAMPLE, slot_chan[$urandom_range(NUM_SLOTS - 1)], raw);
            else
                push_word(REQ_SAMPLE, CHAN_W'($urandom), raw);
        end
    endtask

    task automatic write_slot_channel(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CHAN_W-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        // the spare index does not reach any slot
        if (idx < NUM_CFG_REGS && idx < NUM_SLOTS)
            slot_chan[idx] = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every word to go through, then let the pipe settle
    task automatic drain();
        while (adc_words.size() != 0 || accepted_count != offered_count ||
               pending_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_chan[s] = slot_reset_id(s);
            avg_acc[s]   = '0;
            seeded[s]    = 1'b0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // phase one: reset channel table, no idling, directed words first
        push_word(REQ_SAMPLE, 5'd0, 12'd0);
        push_word(REQ_SAMPLE, 5'd0, 12'hfff);
        push_word(REQ_SAMPLE, 5'd0, 12'hfff);
        push_word(REQ_SAMPLE, 5'd2, 12'hfff);
        push_word(REQ_SAMPLE, 5'd2, 12'hfff);
        push_word(REQ_SAMPLE, 5'd2, 12'd0);
        push_word(REQ_SAMPLE, 5'd6, 12'haaa);
        push_word(REQ_SAMPLE, 5'd6, 12'h555);
        push_word(REQ_SAMPLE, 5'd31, 12'hfff);
        push_word(REQ_SAMPLE, 5'd1, 12'd1);
        push_word(REQ_SAMPLE, 5'h15, 12'h800);
        push_word(REQ_SAMPLE, 5'h0a, 12'h7ff);
        // clear with nonzero fields, then reseed
        push_word(REQ_CLEAR, 5'd31, 12'hfff);
        push_word(REQ_SAMPLE, 5'd0, 12'd123);
        push_word(REQ_SAMPLE, 5'd2, 12'hfff);
        push_word(REQ_CLEAR, 5'd0, 12'd0);
        push_word(REQ_CLEAR, 5'd0, 12'd0);
        // full-scale run on one slot drives that slot's average to full scale
        for (int n = 0; n < 5; n++)
            push_word(REQ_SAMPLE, 5'd6, 12'hfff);
        push_word(REQ_SAMPLE, 5'd6, 12'd0);
        holds_asked++;
        push_random(RANDOM_WORDS);
        drain();

        // phase two: extreme and duplicate ids, sender idles
        write_slot_channel(CFG_CHANNEL_A, 5'd31);
        write_slot_channel(CFG_CHANNEL_B, 5'd0);
        write_slot_channel(CFG_CHANNEL_C, 5'd31);
        write_slot_channel(CFG_INDEX_SPARE, 5'd6);
        send_idle_pct = 63;
        push_word(REQ_SAMPLE, 5'd31, 12'hfff);
        push_word(REQ_SAMPLE, 5'd31, 12'd0);
        push_word(REQ_SAMPLE, 5'd0, 12'd100);
        push_word(REQ_SAMPLE, 5'd6, 12'd77);
        push_random(RANDOM_WORDS);
        drain();

        // phase three: random ids, receiver stalls
        write_slot_channel(CFG_CHANNEL_A, CHAN_W'($urandom));
        write_slot_channel(CFG_CHANNEL_B, CHAN_W'($urandom));
        write_slot_channel(CFG_CHANNEL_C, CHAN_W'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        push_random(RANDOM_WORDS);
        drain();

        // phase four: both sides idle
        write_slot_channel(CFG_CHANNEL_A, 5'd0);
        write_slot_channel(CFG_CHANNEL_B, 5'd31);
        write_slot_channel(CFG_CHANNEL_C, 5'd21);
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        push_random(RANDOM_WORDS);
        drain();

        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/mcema_pkg.sv
src/mcema_front.sv
src/mcema_queue.sv
src/mcema_back.sv
src/multichannel_ema_adc_filter.sv
test/tb.sv
